@@ hw/rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MHFE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MHFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is also checked during reset
`define MHFE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mhfe_pkg.sv @@
// shared types, constants and the header text table of the frame extractor
`default_nettype none

package mhfe_pkg;

    // width of the max_frame_bytes register
    localparam int CFG_W = 24;
    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 24'hFFFFFF;

    // header text length and special characters
    localparam int HDR_LEN = 16;
    localparam logic [7:0] CHR_CR   = 8'h0d;
    localparam logic [7:0] CHR_LF   = 8'h0a;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_BLANK   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4
    } t_phase;

    // one result transaction from the parser to the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_result;

    // characters of "Content-Length: "
    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6f; // o
            4'd2:    c = 8'h6e; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6e; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2d; // -
            4'd8:    c = 8'h4c; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6e; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3a; // :
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

    // characters of CR LF CR LF
    function automatic logic [7:0] blank_char(input logic [1:0] idx);
        return idx[0] ? CHR_LF : CHR_CR;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mhfe_ifs.sv @@
// valid/ready stream interfaces for the input byte and the payload result
`default_nettype none

interface mhfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mhfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_of_frame;

    modport source (output valid, output payload_byte, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mhfe_parser.sv @@
// input register and the per-byte deframing state machine
`default_nettype none

module mhfe_parser
    import mhfe_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mhfe_in_if.sink               i_stream,
    input  wire logic [CFG_W-1:0] i_max_frame_bytes,
    input  wire logic             i_out_free,
    output t_result               o_res
);

    localparam int CMP_W = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
    localparam int ACC_W = LENGTH_BITS + 4;

    logic                   r_in_vld;
    logic [7:0]             r_in_byte;
    t_phase                 r_phase, n_phase;
    logic [3:0]             r_match_pos, n_match_pos;
    logic [LENGTH_BITS-1:0] r_length_acc, n_length_acc;
    logic [1:0]             r_line_end_cnt, n_line_end_cnt;
    logic [LENGTH_BITS-1:0] r_bytes_rem, n_bytes_rem;

    logic                   advance;
    logic                   in_ready;
    logic                   is_digit;
    logic [7:0]             digit_raw;
    logic [ACC_W-1:0]       acc_ext;
    logic [ACC_W-1:0]       acc_next;
    logic [1:0]             blank_idx;
    logic                   blank_hit;
    logic                   too_long;
    logic                   rem_last;

    // the byte in the input register moves on when the output stage has room
    assign advance  = r_in_vld & i_out_free;
    assign in_ready = ~r_in_vld | advance;
    assign i_stream.ready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_stream.valid;
        end
        if (in_ready && i_stream.valid) begin
            r_in_byte <= i_stream.stream_byte;
        end
    end

    // decimal accumulate with saturation
    assign is_digit  = (r_in_byte >= CHR_ZERO) && (r_in_byte <= CHR_NINE);
    assign digit_raw = r_in_byte - CHR_ZERO;
    assign acc_ext   = ACC_W'(r_length_acc);
    assign acc_next  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit_raw[3:0]);

    // blank line matcher, restarted at zero on the byte that ends the digits
    assign blank_idx = (r_phase == PH_BLANK) ? r_line_end_cnt : 2'd0;
    assign blank_hit = (r_in_byte == blank_char(blank_idx));
    assign too_long  = CMP_W'(r_length_acc) > CMP_W'(i_max_frame_bytes);
    assign rem_last  = (r_bytes_rem[LENGTH_BITS-1:1] == '0);

    // next state and result
    always_comb begin
        n_phase        = r_phase;
        n_match_pos    = r_match_pos;
        n_length_acc   = r_length_acc;
        n_line_end_cnt = r_line_end_cnt;
        n_bytes_rem    = r_bytes_rem;
        o_res.valid         = 1'b0;
        o_res.payload_byte  = r_in_byte;
        o_res.last_of_frame = 1'b0;

        case (r_phase)
            PH_DIGITS, PH_BLANK: begin
                if (r_phase == PH_DIGITS && is_digit) begin
                    if (acc_next[ACC_W-1:LENGTH_BITS] != '0) begin
                        n_length_acc = '1;
                    end else begin
                        n_length_acc = acc_next[LENGTH_BITS-1:0];
                    end
                end else begin
                    n_phase = PH_BLANK;
                    if (blank_hit) begin
                        if (blank_idx == 2'd3) begin
                            n_line_end_cnt = 2'd0;
                            n_bytes_rem    = r_length_acc;
                            if (r_length_acc == '0) begin
                                n_phase = PH_SEARCH;
                            end else if (too_long) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end else begin
                            n_line_end_cnt = blank_idx + 2'd1;
                        end
                    end else begin
                        n_line_end_cnt = (r_in_byte == CHR_CR) ? 2'd1 : 2'd0;
                    end
                end
            end
            PH_PAYLOAD, PH_SKIP: begin
                o_res.valid = advance && (r_phase == PH_PAYLOAD);
                if (rem_last) begin
                    o_res.last_of_frame = 1'b1;
                    n_bytes_rem = '0;
                    n_phase     = PH_SEARCH;
                    n_match_pos = 4'd0;
                end else begin
                    n_bytes_rem = r_bytes_rem - LENGTH_BITS'(1);
                end
            end
            default: begin
                n_phase = PH_SEARCH;
                if (r_in_byte == hdr_char(r_match_pos)) begin
                    if (r_match_pos == 4'(HDR_LEN - 1)) begin
                        n_match_pos    = 4'd0;
                        n_length_acc   = '0;
                        n_line_end_cnt = 2'd0;
                        n_phase        = PH_DIGITS;
                    end else begin
                        n_match_pos = r_match_pos + 4'd1;
                    end
                end else begin
                    n_match_pos = (r_in_byte == hdr_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end
        endcase
    end

    // state registers, stepped once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SEARCH;
            r_match_pos    <= 4'd0;
            r_length_acc   <= '0;
            r_line_end_cnt <= 2'd0;
            r_bytes_rem    <= '0;
        end else if (advance) begin
            r_phase        <= n_phase;
            r_match_pos    <= n_match_pos;
            r_length_acc   <= n_length_acc;
            r_line_end_cnt <= n_line_end_cnt;
            r_bytes_rem    <= n_bytes_rem;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mhfe_out_stage.sv @@
// result register that holds a payload transaction until it is taken
`default_nettype none

module mhfe_out_stage
    import mhfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_result   i_res,
    output logic      o_free,
    mhfe_out_if.source o_frame
);

    logic       r_out_vld;
    logic [7:0] r_payload_byte;
    logic       r_last_of_frame;

    // room when empty or when the held transaction leaves this cycle
    assign o_free = ~r_out_vld | o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_free) begin
            r_out_vld <= i_res.valid;
        end
        if (o_free && i_res.valid) begin
            r_payload_byte  <= i_res.payload_byte;
            r_last_of_frame <= i_res.last_of_frame;
        end
    end

    assign o_frame.valid         = r_out_vld;
    assign o_frame.payload_byte  = r_payload_byte;
    assign o_frame.last_of_frame = r_last_of_frame;

endmodule

`default_nettype wire

@@ hw/rtl/mjpeg_http_frame_extractor_unit.sv @@
// top level of the MJPEG multipart frame extractor
// Takes the HTTP multipart body one byte per transaction and passes on only the
// JPEG payload bytes, the length coming from the "Content-Length: " header and
// the payload starting after the following blank line; last_of_frame marks the
// final byte. A new byte is accepted in every cycle while the output is taken:
// each byte goes through an input register, one step of the header state
// machine and a result register, so a payload byte is presented on the output
// from the result register once that register has room for it.
// Discarded bytes produce no transaction. Frames longer than
// max_frame_bytes, and zero-length frames, are dropped whole. There is no
// clearing pass after reset; max_frame_bytes should be written only while the
// block is idle.
`default_nettype none

module mjpeg_http_frame_extractor_unit
    import mhfe_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mhfe_in_if.sink               i_stream,
    mhfe_out_if.source            o_frame,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_max_frame_bytes;
    t_result          res;
    logic             out_free;

    // max_frame_bytes register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_bytes <= MAX_FRAME_RESET;
        end else if (i_cfg_we) begin
            r_max_frame_bytes <= i_cfg_wdata;
        end
    end

    mhfe_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_stream          (i_stream),
        .i_max_frame_bytes (r_max_frame_bytes),
        .i_out_free        (out_free),
        .o_res             (res)
    );

    mhfe_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_frame (o_frame)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mhfe_checker.sv @@
// port-level checks of the frame extractor, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module mhfe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_payload_byte,
    input wire logic       i_last_of_frame
);

    // reset empties the result register
    `MHFE_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

    // with nothing waiting at the output the input can never be blocked
    `MHFE_ASSERT_IMPL(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // a fresh result comes from a byte accepted at the input and held in the input register
    `MHFE_ASSERT_IMPL(a_out_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "result without matching input")

    // a stalled payload transaction holds its contents
    `MHFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_payload_byte) && $stable(i_last_of_frame), "stalled output changed")

endmodule

bind mjpeg_http_frame_extractor_unit mhfe_checker u_mhfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_stream.valid),
    .i_in_ready      (i_stream.ready),
    .i_out_valid     (o_frame.valid),
    .i_out_ready     (o_frame.ready),
    .i_payload_byte  (o_frame.payload_byte),
    .i_last_of_frame (o_frame.last_of_frame)
);

`default_nettype wire
